FILE: design/ppi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position to pad index: shared definitions
// Field widths, module geometry in 0.005 mm units and register indexes.
// ----------------------------------------------------------------------------
package ppi_pkg;

   // Field and register widths
   localparam int POS_W   = 18;
   localparam int PITCH_W = 13;
   localparam int AREA_W  = 16;
   localparam int MOD_W   = 3;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 6;
   localparam int CSR_W   = 16;

   // Offsets inside a pad area reach at most twice the area size.
   localparam int OFF_W  = AREA_W + 1;
   // Signed distance of a doubled coordinate from a doubled centre.
   localparam int DIFF_W = 20;

   // Default pad counts
   localparam int PADS_Y_DEF = 32;
   localparam int PADS_Z_DEF = 36;

   // Module layout: two rows of four, numbered row * COLS + column.
   localparam int ROWS          = 2;
   localparam int COLS          = 4;
   localparam int MODULES       = 8;
   localparam int WINDOW_MODULE = 3;

   // Module centres in 0.005 mm units.
   localparam logic signed [DIFF_W-1:0] CENTRE_Y2 [ROWS] = '{
      20'sd34100, -20'sd34100
   };
   localparam logic signed [DIFF_W-1:0] CENTRE_Z2 [COLS] = '{
      -20'sd126300, -20'sd42100, 20'sd42100, 20'sd126300
   };

   // Window aperture of the windowed module, in 0.01 mm units.
   localparam logic signed [POS_W-1:0] WIN_Y_MIN = 18'sd3350;
   localparam logic signed [POS_W-1:0] WIN_Y_MAX = 18'sd30750;
   localparam logic signed [POS_W-1:0] WIN_Z_MIN = 18'sd52950;
   localparam logic signed [POS_W-1:0] WIN_Z_MAX = 18'sd80350;

   // Register reset values
   localparam logic [PITCH_W-1:0] PITCH_Y_RST     = 13'd1017;
   localparam logic [PITCH_W-1:0] PITCH_Z_RST     = 13'd1128;
   localparam logic [AREA_W-1:0]  AREA_HEIGHT_RST = 16'd32532;
   localparam logic [AREA_W-1:0]  AREA_WIDTH_RST  = 16'd40596;

   typedef enum logic [1:0] {
      CSR_PITCH_Y     = 2'd0,
      CSR_PITCH_Z     = 2'd1,
      CSR_AREA_HEIGHT = 2'd2,
      CSR_AREA_WIDTH  = 2'd3
   } csr_index_type;

endpackage

FILE: design/ppi_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position to pad index: module search
// Two stages: the first tests the rows, columns and window and picks the
// first module that holds the point; the second forms the offsets from the
// lower corner of that module's pad area.
// ----------------------------------------------------------------------------
module ppi_locate
   import ppi_pkg::*;
(
   input  logic                     clock,
   input  logic [1:0]               en,
   input  logic signed [POS_W-1:0]  pos_y,
   input  logic signed [POS_W-1:0]  pos_z,
   input  logic [AREA_W-1:0]        area_height,
   input  logic [AREA_W-1:0]        area_width,
   output logic                     hit,
   output logic [MOD_W-1:0]         module_id,
   output logic [OFF_W-1:0]         off_y,
   output logic [OFF_W-1:0]         off_z
);

   logic signed [DIFF_W-1:0] y2;
   logic signed [DIFF_W-1:0] z2;
   logic signed [DIFF_W-1:0] h_ext;
   logic signed [DIFF_W-1:0] w_ext;
   logic signed [DIFF_W-1:0] dy [ROWS];
   logic signed [DIFF_W-1:0] dz [COLS];
   logic [ROWS-1:0]          row_in;
   logic [COLS-1:0]          col_in;
   logic                     win_in;

   logic                     hit1_in;
   logic [MOD_W-1:0]         id1_in;
   logic signed [DIFF_W-1:0] dy1_in;
   logic signed [DIFF_W-1:0] dz1_in;

   logic                     hit1_ff;
   logic [MOD_W-1:0]         id1_ff;
   logic signed [DIFF_W-1:0] dy1_ff;
   logic signed [DIFF_W-1:0] dz1_ff;

   logic signed [DIFF_W-1:0] sum_y;
   logic signed [DIFF_W-1:0] sum_z;

   logic                     hit2_ff;
   logic [MOD_W-1:0]         id2_ff;
   logic [OFF_W-1:0]         off_y2_ff;
   logic [OFF_W-1:0]         off_z2_ff;

   // Coordinates are doubled so that half area sizes stay exact.
   assign y2    = DIFF_W'(signed'({pos_y, 1'b0}));
   assign z2    = DIFF_W'(signed'({pos_z, 1'b0}));
   assign h_ext = signed'({{(DIFF_W-AREA_W){1'b0}}, area_height});
   assign w_ext = signed'({{(DIFF_W-AREA_W){1'b0}}, area_width});

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         dy[r]     = y2 - CENTRE_Y2[r];
         row_in[r] = (dy[r] >= -h_ext) && (dy[r] <= h_ext);
      end
      for (int c = 0; c < COLS; c++) begin
         dz[c]     = z2 - CENTRE_Z2[c];
         col_in[c] = (dz[c] >= -w_ext) && (dz[c] <= w_ext);
      end
   end

   assign win_in = (pos_y >= WIN_Y_MIN) && (pos_y <= WIN_Y_MAX) &&
                   (pos_z >= WIN_Z_MIN) && (pos_z <= WIN_Z_MAX);

   // The lowest numbered module that holds the point wins.
   always_comb begin
      hit1_in = 1'b0;
      id1_in  = '0;
      dy1_in  = '0;
      dz1_in  = '0;
      for (int m = 0; m < MODULES; m++) begin
         if (!hit1_in && row_in[m / COLS] && col_in[m % COLS] &&
             ((m != WINDOW_MODULE) || win_in)) begin
            hit1_in = 1'b1;
            id1_in  = MOD_W'(m);
            dy1_in  = dy[m / COLS];
            dz1_in  = dz[m % COLS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hit1_ff <= hit1_in;
         id1_ff  <= id1_in;
         dy1_ff  <= dy1_in;
         dz1_ff  <= dz1_in;
      end
   end

   // On a hit the sums lie in 0 .. twice the area size, so they fit OFF_W.
   assign sum_y = dy1_ff + h_ext;
   assign sum_z = dz1_ff + w_ext;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hit2_ff   <= hit1_ff;
         id2_ff    <= id1_ff;
         off_y2_ff <= sum_y[OFF_W-1:0];
         off_z2_ff <= sum_z[OFF_W-1:0];
      end
   end

   assign hit       = hit2_ff;
   assign module_id = id2_ff;
   assign off_y     = off_y2_ff;
   assign off_z     = off_z2_ff;

endmodule

FILE: design/ppi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position to pad index: pipelined pad divider
// Restoring division of an offset by twice the pitch, one quotient bit per
// stage, with the quotient clamped to the pad count minus one.
// ----------------------------------------------------------------------------
module ppi_div
   import ppi_pkg::*;
#(
   parameter int COUNT = PADS_Y_DEF,
   parameter int QW    = 5
)
(
   input  logic                 clock,
   input  logic [QW-1:0]        en,
   input  logic [PITCH_W-1:0]   pitch,
   input  logic [OFF_W-1:0]     off,
   output logic [QW-1:0]        idx
);

   localparam int LIM_W = PITCH_W + 1 + QW;
   localparam int CMP_W = (OFF_W > LIM_W) ? OFF_W : LIM_W;

   logic [PITCH_W:0]   divisor;
   logic [CMP_W-1:0]   lim_in;
   logic [CMP_W-1:0]   lim_ff;

   logic [OFF_W-1:0]   r_src [QW];
   logic [QW-1:0]      q_src [QW];
   logic               sat_src [QW];
   logic [CMP_W-1:0]   shifted [QW];
   logic [CMP_W-1:0]   diff [QW];
   logic               ge [QW];

   logic [OFF_W-1:0]   r_in [QW];
   logic [QW-1:0]      q_in [QW];
   logic [OFF_W-1:0]   r_ff [QW];
   logic [QW-1:0]      q_ff [QW];
   logic               sat_ff [QW];

   assign divisor = {pitch, 1'b0};

   // The pitch must only be changed while the block is idle; the block itself does
   // not enforce this. The limit is then settled before any request reaches the first stage.
   assign lim_in = CMP_W'(COUNT) * CMP_W'(divisor);

   always_ff @(posedge clock) begin
      lim_ff <= lim_in;
   end

   always_comb begin
      for (int j = 0; j < QW; j++) begin
         if (j == 0) begin
            r_src[j]   = off;
            q_src[j]   = '0;
            sat_src[j] = CMP_W'(off) >= lim_ff;
         end else begin
            r_src[j]   = r_ff[j-1];
            q_src[j]   = q_ff[j-1];
            sat_src[j] = sat_ff[j-1];
         end
         shifted[j] = CMP_W'(divisor) << (QW - 1 - j);
         ge[j]      = CMP_W'(r_src[j]) >= shifted[j];
         diff[j]    = CMP_W'(r_src[j]) - shifted[j];
         r_in[j]    = ge[j] ? diff[j][OFF_W-1:0] : r_src[j];
         q_in[j]    = QW'({q_src[j], ge[j]});
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         if (en[j]) begin
            r_ff[j]   <= r_in[j];
            q_ff[j]   <= q_in[j];
            sat_ff[j] <= sat_src[j];
         end
      end
   end

   // A saturated offset, which includes a zero pitch, takes the last pad.
   assign idx = sat_ff[QW-1] ? QW'(COUNT - 1) : q_ff[QW-1];

endmodule

FILE: design/position_to_pad_index_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position to pad index
// Finds the detector module and the pad that hold a hit position.
// ----------------------------------------------------------------------------
// One request may enter in every cycle while the pipeline has room. QW is the
// number of quotient bits for the larger pad count (six at the default
// counts); the pipeline depth is set by
// the pad dividers, which resolve one quotient bit per stage. The pipeline
// squeezes out empty stages when the response side stalls, so requests are
// taken until every stage is full. Register writes take effect at once; the
// user must make them only while no request is in flight (not enforced here).
module position_to_pad_index_top
   import ppi_pkg::*;
#(
   parameter int PADS_Y = PADS_Y_DEF,
   parameter int PADS_Z = PADS_Z_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [MOD_W-1:0]         rsp_module_id,
   output logic [ROW_W-1:0]         rsp_pad_row,
   output logic [COL_W-1:0]         rsp_pad_col,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   localparam int QW_Y  = $clog2(PADS_Y);
   localparam int QW_Z  = $clog2(PADS_Z);
   localparam int QW_YZ = (QW_Y > QW_Z) ? QW_Y : QW_Z;
   localparam int QW    = (QW_YZ > 1) ? QW_YZ : 1;

   // Stage map: input register, two search stages, divider, response.
   localparam int S_LOC = 1;
   localparam int S_DIV = 3;
   localparam int S_OUT = S_DIV + QW;
   localparam int NS    = S_OUT + 1;

   logic [PITCH_W-1:0]     pitch_y_ff;
   logic [PITCH_W-1:0]     pitch_z_ff;
   logic [AREA_W-1:0]      area_height_ff;
   logic [AREA_W-1:0]      area_width_ff;

   logic [NS:0]            ready;
   logic [NS-1:0]          en;
   logic [NS-1:0]          valid_in;
   logic [NS-1:0]          valid_ff;

   logic signed [POS_W-1:0] pos_y_ff;
   logic signed [POS_W-1:0] pos_z_ff;

   logic                   loc_hit;
   logic [MOD_W-1:0]       loc_module_id;
   logic [OFF_W-1:0]       loc_off_y;
   logic [OFF_W-1:0]       loc_off_z;

   logic                   hit_pipe_ff [QW];
   logic [MOD_W-1:0]       id_pipe_ff [QW];

   logic [QW-1:0]          idx_y;
   logic [QW-1:0]          idx_z;

   logic                   rsp_hit_ff;
   logic [MOD_W-1:0]       rsp_module_id_ff;
   logic [ROW_W-1:0]       rsp_pad_row_ff;
   logic [COL_W-1:0]       rsp_pad_col_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_y_ff     <= PITCH_Y_RST;
         pitch_z_ff     <= PITCH_Z_RST;
         area_height_ff <= AREA_HEIGHT_RST;
         area_width_ff  <= AREA_WIDTH_RST;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PITCH_Y:     pitch_y_ff     <= csr_data[PITCH_W-1:0];
            CSR_PITCH_Z:     pitch_z_ff     <= csr_data[PITCH_W-1:0];
            CSR_AREA_HEIGHT: area_height_ff <= csr_data[AREA_W-1:0];
            CSR_AREA_WIDTH:  area_width_ff  <= csr_data[AREA_W-1:0];
         endcase
      end
   end

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      ready[NS] = !rsp_stall;
      for (int k = NS - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      en = ready[NS-1:0];
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            valid_in[k] = ready[k] ? req_valid : valid_ff[k];
         end else begin
            valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NS-1];

   // Input register
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
      end
   end

   ppi_locate u_locate (
      .clock       (clock),
      .en          (en[S_LOC +: 2]),
      .pos_y       (pos_y_ff),
      .pos_z       (pos_z_ff),
      .area_height (area_height_ff),
      .area_width  (area_width_ff),
      .hit         (loc_hit),
      .module_id   (loc_module_id),
      .off_y       (loc_off_y),
      .off_z       (loc_off_z)
   );

   ppi_div #(
      .COUNT (PADS_Y),
      .QW    (QW)
   ) u_div_y (
      .clock (clock),
      .en    (en[S_DIV +: QW]),
      .pitch (pitch_y_ff),
      .off   (loc_off_y),
      .idx   (idx_y)
   );

   ppi_div #(
      .COUNT (PADS_Z),
      .QW    (QW)
   ) u_div_z (
      .clock (clock),
      .en    (en[S_DIV +: QW]),
      .pitch (pitch_z_ff),
      .off   (loc_off_z),
      .idx   (idx_z)
   );

   // The hit flag and module number ride alongside the divider stages.
   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         if (en[S_DIV + j]) begin
            if (j == 0) begin
               hit_pipe_ff[j] <= loc_hit;
               id_pipe_ff[j]  <= loc_module_id;
            end else begin
               hit_pipe_ff[j] <= hit_pipe_ff[j-1];
               id_pipe_ff[j]  <= id_pipe_ff[j-1];
            end
         end
      end
   end

   // Response register; a miss reports zero in every field.
   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         rsp_hit_ff       <= hit_pipe_ff[QW-1];
         rsp_module_id_ff <= hit_pipe_ff[QW-1] ? id_pipe_ff[QW-1] : '0;
         rsp_pad_row_ff   <= hit_pipe_ff[QW-1] ? ROW_W'(idx_y) : '0;
         rsp_pad_col_ff   <= hit_pipe_ff[QW-1] ? COL_W'(idx_z) : '0;
      end
   end

   assign rsp_hit       = rsp_hit_ff;
   assign rsp_module_id = rsp_module_id_ff;
   assign rsp_pad_row   = rsp_pad_row_ff;
   assign rsp_pad_col   = rsp_pad_col_ff;

`ifndef SYNTHESIS
   a_miss_zero : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_module_id == '0) && (rsp_pad_row == '0) && (rsp_pad_col == '0)
   ) else $error("missed request reports non-zero indices");

   a_stall_when_full : assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall)
   ) else $error("request stalled while the pipeline has room");

   a_reset_empty : assert property (
      @(posedge clock)
      reset |=> (valid_ff == '0)
   ) else $error("pipeline not empty after reset");
`endif

endmodule

FILE: test/pad_index_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position to pad index: response checker
// Follows the register writes, works out the module and pad for every
// accepted request and compares each response with the oldest one waiting.
// ----------------------------------------------------------------------------
module pad_index_checker
   import ppi_pkg::*;
#(
   parameter int PADS_Y = PADS_Y_DEF,
   parameter int PADS_Z = PADS_Z_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_hit,
   input  logic [MOD_W-1:0]         rsp_module_id,
   input  logic [ROW_W-1:0]         rsp_pad_row,
   input  logic [COL_W-1:0]         rsp_pad_col,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [CSR_W-1:0]         csr_data,
   output int                       errors,
   output int                       pending
);

   typedef struct packed {
      logic             hit;
      logic [MOD_W-1:0] module_id;
      logic [ROW_W-1:0] pad_row;
      logic [COL_W-1:0] pad_col;
   } pad_location_type;

   logic [PITCH_W-1:0] pitch_y;
   logic [PITCH_W-1:0] pitch_z;
   logic [AREA_W-1:0]  area_height;
   logic [AREA_W-1:0]  area_width;

   pad_location_type expected_pads[$];

   // The offset is in 0.005 mm and the pitch in 0.01 mm, hence the factor of two.
   function automatic longint pad_index(longint off2, longint pitch, longint count);
      longint idx;
      if (off2 < 0) begin
         off2 = 0;
      end
      if (pitch == 0) begin
         return count - 1;
      end
      idx = off2 / (2 * pitch);
      if (idx > count - 1) begin
         idx = count - 1;
      end
      return idx;
   endfunction

   function automatic pad_location_type locate_pad(longint y, longint z);
      pad_location_type loc;
      longint           y2, z2, cy2, cz2, h, w;
      bit               in_area, in_window;
      loc       = '0;
      y2        = 2 * y;
      z2        = 2 * z;
      h         = area_height;
      w         = area_width;
      in_window = (y >= WIN_Y_MIN) && (y <= WIN_Y_MAX) &&
                  (z >= WIN_Z_MIN) && (z <= WIN_Z_MAX);
      for (int id = 0; id < MODULES; id++) begin
         cy2     = CENTRE_Y2[id / COLS];
         cz2     = CENTRE_Z2[id % COLS];
         in_area = (y2 >= cy2 - h) && (y2 <= cy2 + h) &&
                   (z2 >= cz2 - w) && (z2 <= cz2 + w);
         // The windowed module only counts inside its aperture; later
         // modules may still claim the point.
         if (in_area && (id != WINDOW_MODULE || in_window)) begin
            loc.hit       = 1'b1;
            loc.module_id = MOD_W'(id);
            loc.pad_row   = ROW_W'(pad_index(y2 - cy2 + h, pitch_y, PADS_Y));
            loc.pad_col   = COL_W'(pad_index(z2 - cz2 + w, pitch_z, PADS_Z));
            return loc;
         end
      end
      return loc;
   endfunction

   task automatic report_mismatch(string msg);
      // Keep the log short when the design is badly broken.
      if (errors < 40) begin
         $display("%0t ns: %s", $time, msg);
      end
      errors++;
   endtask

   always @(posedge clock) begin
      pad_location_type want;
      if (reset) begin
         pitch_y     <= PITCH_Y_RST;
         pitch_z     <= PITCH_Z_RST;
         area_height <= AREA_HEIGHT_RST;
         area_width  <= AREA_WIDTH_RST;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_PITCH_Y:     pitch_y     <= csr_data[PITCH_W-1:0];
               CSR_PITCH_Z:     pitch_z     <= csr_data[PITCH_W-1:0];
               CSR_AREA_HEIGHT: area_height <= csr_data[AREA_W-1:0];
               CSR_AREA_WIDTH:  area_width  <= csr_data[AREA_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pads.size() == 0) begin
               report_mismatch($sformatf("response with no request outstanding: hit %0d module %0d",
                                         rsp_hit, rsp_module_id));
            end else begin
               want = expected_pads.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit %0d, expected %0d", rsp_hit, want.hit));
               if (rsp_module_id !== want.module_id)
                  report_mismatch($sformatf("module_id %0d, expected %0d",
                                            rsp_module_id, want.module_id));
               if (rsp_pad_row !== want.pad_row)
                  report_mismatch($sformatf("pad_row %0d, expected %0d",
                                            rsp_pad_row, want.pad_row));
               if (rsp_pad_col !== want.pad_col)
                  report_mismatch($sformatf("pad_col %0d, expected %0d",
                                            rsp_pad_col, want.pad_col));
            end
         end
         if (req_valid && !req_stall) begin
            expected_pads = {expected_pads, locate_pad(req_pos_y, req_pos_z)};
         end
      end
      pending = expected_pads.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position to pad index: testbench
// Drives hit positions through several register settings, from the smallest
// to the largest pitches and areas, with random gaps on both sides and a
// long response stall in two of the passes, and leaves the checking to the checker.
// ----------------------------------------------------------------------------
module tb_top;
   import ppi_pkg::*;

   typedef struct packed {
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } hit_pos_type;

   localparam int N_DIRECTED = 24;
   // Directed points, worked out for the register values after reset.
   localparam int DIR_Y [N_DIRECTED] = '{
      0, 17050, 784, 33316, 783, 17050, -17050, -784, 17050, 3349, 3350, 30750,
      30751, 17050, 131071, -131072, 131071, -131072, -17050, 17050, 17050,
      -17050, -17050, -1
   };
   localparam int DIR_Z [N_DIRECTED] = '{
      0, -63150, -83448, -42852, -63150, -42851, 63150, 83448, 63150, 63150,
      52950, 80350, 80350, 80351, 131071, -131072, -131072, 131071, -21050,
      21050, -21050, -63150, 21050, -1
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [POS_W-1:0] req_pos_y;
   logic signed [POS_W-1:0] req_pos_z;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_hit;
   logic [MOD_W-1:0]        rsp_module_id;
   logic [ROW_W-1:0]        rsp_pad_row;
   logic [COL_W-1:0]        rsp_pad_col;
   logic                    csr_write_en;
   logic [1:0]              csr_index;
   logic [CSR_W-1:0]        csr_data;

   int errors;
   int pending;
   int cur_height;
   int cur_width;
   bit no_gaps;
   int hold_requests;

   position_to_pad_index_top u_top (.*);
   pad_index_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic longint clamp_pos(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   // Mostly points aimed at a module area, its edges or the window aperture,
   // the rest anywhere in the field range.
   function automatic hit_pos_type pick_point();
      hit_pos_type p;
      longint      cy, cz, y, z;
      int          id, kind, half_h, half_w;
      id     = $urandom_range(0, MODULES - 1);
      cy     = CENTRE_Y2[id / COLS];
      cy     = cy / 2;
      cz     = CENTRE_Z2[id % COLS];
      cz     = cz / 2;
      half_h = cur_height / 2;
      half_w = cur_width / 2;
      kind   = $urandom_range(0, 99);
      if (kind < 50) begin
         y = cy - half_h - 2 + int'($urandom_range(0, cur_height + 4));
         z = cz - half_w - 2 + int'($urandom_range(0, cur_width + 4));
      end else if (kind < 65) begin
         y = cy + ($urandom_range(0, 1) ? half_h : -half_h) + int'($urandom_range(0, 4)) - 2;
         z = cz + ($urandom_range(0, 1) ? half_w : -half_w) + int'($urandom_range(0, 4)) - 2;
         case ($urandom_range(0, 2))
            0: y = cy - half_h + int'($urandom_range(0, cur_height));
            1: z = cz - half_w + int'($urandom_range(0, cur_width));
            default: ;
         endcase
      end else if (kind < 80) begin
         if ($urandom_range(0, 1)) begin
            y = ($urandom_range(0, 1) ? WIN_Y_MIN : WIN_Y_MAX) + int'($urandom_range(0, 4)) - 2;
            z = WIN_Z_MIN - 3 + int'($urandom_range(0, WIN_Z_MAX - WIN_Z_MIN + 6));
         end else begin
            y = WIN_Y_MIN - 3 + int'($urandom_range(0, WIN_Y_MAX - WIN_Y_MIN + 6));
            z = ($urandom_range(0, 1) ? WIN_Z_MIN : WIN_Z_MAX) + int'($urandom_range(0, 4)) - 2;
         end
      end else begin
         y = $signed(POS_W'($urandom));
         z = $signed(POS_W'($urandom));
      end
      p.y = POS_W'(clamp_pos(y));
      p.z = POS_W'(clamp_pos(z));
      return p;
   endfunction

   function automatic logic [CSR_W-1:0] random_pitch_data();
      // Bits above the pitch field are set at random and must be ignored.
      return {3'($urandom), PITCH_W'($urandom_range(1, (1 << PITCH_W) - 1))};
   endfunction

   function automatic logic [CSR_W-1:0] random_area();
      if ($urandom_range(0, 1)) return CSR_W'($urandom_range(20000, 45000));
      return CSR_W'($urandom_range(1, 65535));
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(negedge clock);
   endtask

   task automatic set_config(logic [CSR_W-1:0] py, logic [CSR_W-1:0] pz,
                             logic [CSR_W-1:0] ah, logic [CSR_W-1:0] aw);
      write_reg(CSR_PITCH_Y, py);
      write_reg(CSR_PITCH_Z, pz);
      write_reg(CSR_AREA_HEIGHT, ah);
      write_reg(CSR_AREA_WIDTH, aw);
      csr_write_en <= 1'b0;
      cur_height = ah;
      cur_width  = aw;
   endtask

   task automatic send_point(hit_pos_type p);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_y <= p.y;
      req_pos_z <= p.z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) send_point(pick_point());
   endtask

   // Registers may only change once every request has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      hit_pos_type p;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_pos_y     <= '0;
      req_pos_z     <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_PITCH_Y;
      csr_data      <= '0;
      no_gaps       = 1'b0;
      hold_requests = 0;
      cur_height    = AREA_HEIGHT_RST;
      cur_width     = AREA_WIDTH_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register values after reset: directed corners, edges and window.
      for (int i = 0; i < N_DIRECTED; i++) begin
         p.y = POS_W'(DIR_Y[i]);
         p.z = POS_W'(DIR_Z[i]);
         send_point(p);
      end
      run_random(80);
      drain();

      // Smallest pitches and areas, back to back.
      set_config(CSR_W'(1), CSR_W'(1), CSR_W'(1), CSR_W'(1));
      no_gaps = 1'b1;
      run_random(30);
      drain();

      // Largest values, with the upper data bits of the pitches set, while
      // the response side holds off long enough to fill the pipeline.
      set_config('1, '1, '1, '1);
      hold_requests++;
      run_random(50);
      drain();
      no_gaps = 1'b0;

      // Zero pitch clamps every index to the last pad.
      set_config('0, '0, CSR_W'(30000), CSR_W'(36000));
      run_random(30);
      drain();

      for (int k = 0; k < 5; k++) begin
         set_config(random_pitch_data(), random_pitch_data(), random_area(), random_area());
         no_gaps = (k == 2);
         if (k == 3) hold_requests++;
         run_random(40);
         drain();
      end
      no_gaps = 1'b0;

      set_config(CSR_W'(PITCH_Y_RST), CSR_W'(PITCH_Z_RST),
                 CSR_W'(AREA_HEIGHT_RST), CSR_W'(AREA_WIDTH_RST));
      run_random(40);
      drain();

      repeat (30) @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Response side: random stalls per response, and a long hold-off when
   // the stimulus asks for one.
   initial begin
      int n;
      int holds_done;
      rsp_stall  <= 1'b0;
      holds_done = 0;
      @(negedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            n = 300;
         end else begin
            n = no_gaps ? 0 : $urandom_range(0, 5);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid || reset);
         @(negedge clock);
      end
   end

   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
